### hw/rtl/array_linked_list_manager_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linked list manager
// Clocked implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LINKED_LIST_MANAGER_MACROS_SVH
`define ARRAY_LINKED_LIST_MANAGER_MACROS_SVH

// same-cycle implication
`define ALM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ALM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/alm_pkg.sv
// ----------------------------------------------------------------------------
// alm_pkg
// Shared constants, codes and types of the linked list manager.
// ----------------------------------------------------------------------------
package alm_pkg;

    localparam int ALM_NODES      = 8;
    localparam int ALM_DATA_WIDTH = 32;
    localparam int KIND_W         = 4;
    localparam int FIELD_W        = 32;
    localparam int ST_W           = 2;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

    // operation codes
    localparam logic [KIND_W-1:0] K_INS_HEAD   = 4'd0;
    localparam logic [KIND_W-1:0] K_INS_TAIL   = 4'd1;
    localparam logic [KIND_W-1:0] K_INS_BEFORE = 4'd2;
    localparam logic [KIND_W-1:0] K_INS_AFTER  = 4'd3;
    localparam logic [KIND_W-1:0] K_RM_HEAD    = 4'd4;
    localparam logic [KIND_W-1:0] K_RM_TAIL    = 4'd5;
    localparam logic [KIND_W-1:0] K_RM_BEFORE  = 4'd6;
    localparam logic [KIND_W-1:0] K_RM_AFTER   = 4'd7;
    localparam logic [KIND_W-1:0] K_READ       = 4'd8;

    // store access strobes from the sequencer
    typedef struct packed {
        logic rd_en;
        logic lnk_we;
        logic val_we;
    } t_store_ctl;

endpackage

### hw/rtl/alm_store.sv
// ----------------------------------------------------------------------------
// alm_store
// Link and value memories with a registered read. A fill count marks
// nodes never taken from the free chain; their link reads as index + 1.
// ----------------------------------------------------------------------------
module alm_store
    import alm_pkg::*;
#(
    parameter int NODES      = ALM_NODES,
    parameter int DATA_WIDTH = ALM_DATA_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_store_ctl                       i_ctl,
    input  logic [$clog2(NODES+1)-1:0]       i_rd_addr,
    input  logic [$clog2(NODES+1)-1:0]       i_wl_addr,
    input  logic [$clog2(NODES+1)-1:0]       i_wl_data,
    input  logic [$clog2(NODES+1)-1:0]       i_wv_addr,
    input  logic [DATA_WIDTH-1:0]            i_wv_data,
    output logic [$clog2(NODES+1)-1:0]       o_rd_link,
    output logic [DATA_WIDTH-1:0]            o_rd_value
);

    localparam int LW = $clog2(NODES + 1);
    localparam int AW = $clog2(NODES);
    localparam logic [LW-1:0] NONE = LW'(NODES);

    logic [LW-1:0]         mem_link [NODES];
    logic [DATA_WIDTH-1:0] mem_val  [NODES];

    logic [LW-1:0]         r_lnk;
    logic [DATA_WIDTH-1:0] r_vd;
    logic [LW-1:0]         r_ra;
    logic                  r_fresh;
    logic [LW-1:0]         r_fill;
    logic [LW-1:0]         raw_link;

    // memory ports
    always_ff @(posedge i_clk) begin
        if (i_ctl.lnk_we) begin
            mem_link[i_wl_addr[AW-1:0]] <= i_wl_data;
        end
        if (i_ctl.val_we) begin
            mem_val[i_wv_addr[AW-1:0]] <= i_wv_data;
        end
        if (i_ctl.rd_en) begin
            r_lnk   <= mem_link[i_rd_addr[AW-1:0]];
            r_vd    <= mem_val[i_rd_addr[AW-1:0]];
            r_ra    <= i_rd_addr;
            r_fresh <= (i_rd_addr >= r_fill);
        end
    end

    // fill count: fresh nodes leave the free chain in index order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctl.val_we && i_wv_addr == r_fill && r_fill != NONE) begin
            r_fill <= r_fill + LW'(1);
        end
    end

    // untouched node links to the next index; clamp damaged links to none
    assign raw_link   = r_fresh ? (r_ra + LW'(1)) : r_lnk;
    assign o_rd_link  = (raw_link >= NONE) ? NONE : raw_link;
    assign o_rd_value = r_vd;

endmodule

### hw/rtl/alm_seq.sv
// ----------------------------------------------------------------------------
// alm_seq
// Operation sequencer: walks the list one memory read a cycle (read-out stalls
// on output), then writes up to two links and hands over the result word.
// ----------------------------------------------------------------------------
`include "array_linked_list_manager_macros.svh"

module alm_seq
    import alm_pkg::*;
#(
    parameter int NODES      = ALM_NODES,
    parameter int DATA_WIDTH = ALM_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [KIND_W-1:0]            i_kind,
    input  logic [FIELD_W-1:0]           i_key,
    input  logic [FIELD_W-1:0]           i_value,
    output t_store_ctl                   o_ctl,
    output logic [$clog2(NODES+1)-1:0]   o_rd_addr,
    output logic [$clog2(NODES+1)-1:0]   o_wl_addr,
    output logic [$clog2(NODES+1)-1:0]   o_wl_data,
    output logic [$clog2(NODES+1)-1:0]   o_wv_addr,
    output logic [DATA_WIDTH-1:0]        o_wv_data,
    input  logic [$clog2(NODES+1)-1:0]   i_rd_link,
    input  logic [DATA_WIDTH-1:0]        i_rd_value,
    input  logic                         i_res_free,
    output logic                         o_res_valid,
    output logic [ST_W-1:0]              o_status,
    output logic [FIELD_W-1:0]           o_item,
    output logic                         o_last,
    output logic [$clog2(NODES+1)-1:0]   o_free_head
);

    localparam int LW = $clog2(NODES + 1);
    localparam int SW = $clog2(NODES);
    localparam logic [LW-1:0] NONE      = LW'(NODES);
    localparam logic [SW-1:0] LAST_STEP = SW'(NODES - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WALK = 6'b000010,
        S_NEXT = 6'b000100,
        S_FREE = 6'b001000,
        S_WR2  = 6'b010000,
        S_RESP = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [DATA_WIDTH-1:0] r_key, n_key;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [LW-1:0]         r_head, n_head;
    logic [LW-1:0]         r_free, n_free;
    logic [LW-1:0]         r_cur, n_cur;
    logic [LW-1:0]         r_prev, n_prev;
    logic [LW-1:0]         r_pprev, n_pprev;
    logic [DATA_WIDTH-1:0] r_pval, n_pval;
    logic [LW-1:0]         r_tgt, n_tgt;
    logic [SW-1:0]         r_steps, n_steps;
    logic [LW-1:0]         r_wa, n_wa;
    logic [LW-1:0]         r_wd, n_wd;
    logic [ST_W-1:0]       r_st, n_st;
    logic [DATA_WIDTH-1:0] r_item, n_item;

    logic hit;
    logic at_end;
    logic at_head;

    assign hit     = (i_rd_value == r_key);
    assign at_end  = (i_rd_link == NONE) || (r_steps == LAST_STEP);
    assign at_head = (r_kind == K_INS_HEAD) || (r_head == NONE) ||
                     (r_kind == K_INS_BEFORE && r_prev == NONE);
    assign o_ready = (r_state == S_IDLE);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NONE;
            r_free  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_key   <= n_key;
        r_val   <= n_val;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_pprev <= n_pprev;
        r_pval  <= n_pval;
        r_tgt   <= n_tgt;
        r_steps <= n_steps;
        r_wa    <= n_wa;
        r_wd    <= n_wd;
        r_st    <= n_st;
        r_item  <= n_item;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_key   = r_key;
        n_val   = r_val;
        n_head  = r_head;
        n_free  = r_free;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_pprev = r_pprev;
        n_pval  = r_pval;
        n_tgt   = r_tgt;
        n_steps = r_steps;
        n_wa    = r_wa;
        n_wd    = r_wd;
        n_st    = r_st;
        n_item  = r_item;

        o_ctl       = '0;
        o_rd_addr   = r_head;
        o_wl_addr   = r_cur;
        o_wl_data   = r_free;
        o_wv_addr   = r_free;
        o_wv_data   = r_val;
        o_res_valid = 1'b0;
        o_status    = r_st;
        o_item      = FIELD_W'(r_item);
        o_last      = 1'b1;
        o_free_head = r_free;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind  = i_kind;
                    n_key   = DATA_WIDTH'(i_key);
                    n_val   = DATA_WIDTH'(i_value);
                    n_cur   = r_head;
                    n_prev  = NONE;
                    n_pprev = NONE;
                    n_steps = '0;
                    n_st    = ST_OK;
                    n_item  = '0;
                    case (i_kind)
                        K_INS_HEAD: begin
                            if (r_free == NONE) begin
                                n_st    = ST_FULL;
                                n_state = S_RESP;
                            end else begin
                                o_ctl.rd_en = 1'b1;
                                o_rd_addr   = r_free;
                                n_state     = S_FREE;
                            end
                        end
                        K_INS_TAIL: begin
                            if (r_free == NONE) begin
                                n_st    = ST_FULL;
                                n_state = S_RESP;
                            end else if (r_head == NONE) begin
                                o_ctl.rd_en = 1'b1;
                                o_rd_addr   = r_free;
                                n_state     = S_FREE;
                            end else begin
                                o_ctl.rd_en = 1'b1;
                                n_state     = S_WALK;
                            end
                        end
                        K_INS_BEFORE, K_INS_AFTER, K_RM_HEAD, K_RM_TAIL,
                        K_RM_BEFORE, K_RM_AFTER, K_READ: begin
                            if (r_head == NONE) begin
                                n_st    = ST_EMPTY;
                                n_state = S_RESP;
                            end else begin
                                o_ctl.rd_en = 1'b1;
                                n_state     = S_WALK;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_WALK: begin
                case (r_kind)
                    K_READ: begin
                        if (i_res_free) begin
                            o_res_valid = 1'b1;
                            o_status    = ST_OK;
                            o_item      = FIELD_W'(i_rd_value);
                            o_last      = at_end;
                            if (at_end) begin
                                n_state = S_IDLE;
                            end else begin
                                o_ctl.rd_en = 1'b1;
                                o_rd_addr   = i_rd_link;
                                n_cur       = i_rd_link;
                                n_steps     = r_steps + SW'(1);
                            end
                        end
                    end
                    K_RM_HEAD: begin
                        // unlink the head and push it onto the free chain
                        n_item       = i_rd_value;
                        n_head       = i_rd_link;
                        o_ctl.lnk_we = 1'b1;
                        n_free       = r_cur;
                        n_state      = S_RESP;
                    end
                    K_INS_TAIL, K_RM_TAIL: begin
                        if (at_end) begin
                            n_tgt = i_rd_link;
                            if (r_kind == K_INS_TAIL) begin
                                o_ctl.rd_en = 1'b1;
                                o_rd_addr   = r_free;
                                n_state     = S_FREE;
                            end else begin
                                n_item       = i_rd_value;
                                o_ctl.lnk_we = 1'b1;
                                n_free       = r_cur;
                                if (r_prev == NONE) begin
                                    n_head  = NONE;
                                    n_state = S_RESP;
                                end else begin
                                    n_wa    = r_prev;
                                    n_wd    = NONE;
                                    n_state = S_WR2;
                                end
                            end
                        end else begin
                            o_ctl.rd_en = 1'b1;
                            o_rd_addr   = i_rd_link;
                            n_prev      = r_cur;
                            n_pprev     = r_prev;
                            n_pval      = i_rd_value;
                            n_cur       = i_rd_link;
                            n_steps     = r_steps + SW'(1);
                        end
                    end
                    default: begin
                        // key searches: first match only
                        if (hit) begin
                            n_tgt = i_rd_link;
                            case (r_kind)
                                K_RM_BEFORE: begin
                                    if (r_prev == NONE) begin
                                        n_st    = ST_MISSING;
                                        n_state = S_RESP;
                                    end else begin
                                        n_item       = r_pval;
                                        o_ctl.lnk_we = 1'b1;
                                        o_wl_addr    = r_prev;
                                        n_free       = r_prev;
                                        if (r_pprev == NONE) begin
                                            n_head  = r_cur;
                                            n_state = S_RESP;
                                        end else begin
                                            n_wa    = r_pprev;
                                            n_wd    = r_cur;
                                            n_state = S_WR2;
                                        end
                                    end
                                end
                                K_RM_AFTER: begin
                                    if (i_rd_link == NONE) begin
                                        n_st    = ST_MISSING;
                                        n_state = S_RESP;
                                    end else begin
                                        o_ctl.rd_en = 1'b1;
                                        o_rd_addr   = i_rd_link;
                                        n_state     = S_NEXT;
                                    end
                                end
                                default: begin
                                    if (r_free == NONE) begin
                                        n_st    = ST_FULL;
                                        n_state = S_RESP;
                                    end else begin
                                        o_ctl.rd_en = 1'b1;
                                        o_rd_addr   = r_free;
                                        n_state     = S_FREE;
                                    end
                                end
                            endcase
                        end else if (at_end) begin
                            n_st    = ST_MISSING;
                            n_state = S_RESP;
                        end else begin
                            o_ctl.rd_en = 1'b1;
                            o_rd_addr   = i_rd_link;
                            n_prev      = r_cur;
                            n_pprev     = r_prev;
                            n_pval      = i_rd_value;
                            n_cur       = i_rd_link;
                            n_steps     = r_steps + SW'(1);
                        end
                    end
                endcase
            end

            S_NEXT: begin
                // neighbour after the match: bridge over it, then free it
                n_item       = i_rd_value;
                o_ctl.lnk_we = 1'b1;
                o_wl_addr    = r_cur;
                o_wl_data    = i_rd_link;
                n_wa         = r_tgt;
                n_wd         = r_free;
                n_free       = r_tgt;
                n_state      = S_WR2;
            end

            S_FREE: begin
                // take the free head, store the value, link it in
                n_free       = i_rd_link;
                o_ctl.val_we = 1'b1;
                o_ctl.lnk_we = 1'b1;
                o_wl_addr    = r_free;
                n_wd         = r_free;
                if (at_head) begin
                    o_wl_data = r_head;
                    n_head    = r_free;
                    n_state   = S_RESP;
                end else begin
                    case (r_kind)
                        K_INS_TAIL: begin
                            o_wl_data = NONE;
                            n_wa      = r_cur;
                        end
                        K_INS_BEFORE: begin
                            o_wl_data = r_cur;
                            n_wa      = r_prev;
                        end
                        default: begin
                            o_wl_data = r_tgt;
                            n_wa      = r_cur;
                        end
                    endcase
                    n_state = S_WR2;
                end
            end

            S_WR2: begin
                o_ctl.lnk_we = 1'b1;
                o_wl_addr    = r_wa;
                o_wl_data    = r_wd;
                n_state      = S_RESP;
            end

            S_RESP: begin
                if (i_res_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ALM_ASSERT_IMP(a_link_wr_in_pool, i_clk, i_rst_n, o_ctl.lnk_we, o_wl_addr < NONE, "link write outside pool")
    `ALM_ASSERT_IMP(a_take_needs_free, i_clk, i_rst_n, o_ctl.val_we, r_free != NONE, "node taken from empty free chain")
    `ALM_ASSERT_NXT(a_wr2_then_resp, i_clk, i_rst_n, r_state == S_WR2, r_state == S_RESP, "second link write not followed by response")

endmodule

### hw/rtl/array_linked_list_manager.sv
// Order of work: status-only answers go straight from accept to the response state;
// head insert first reads the free head and head removal the head node; key and tail
// operations walk the list node by node before their link writes and the response.
// Throughput: one operation at a time; set by the single read port walking one link
// per cycle. Read out delivers one word per cycle while the output is taken.
// Reset: synchronous, active low; empty list, free chain 0..NODES-1, no clearing pass.
// ----------------------------------------------------------------------------
// array_linked_list_manager
// Singly linked list in a fixed node pool with a free chain; the result
// word sits in an output register so the next operation may be accepted.
// ----------------------------------------------------------------------------
module array_linked_list_manager
    import alm_pkg::*;
#(
    parameter int NODES      = ALM_NODES,
    parameter int DATA_WIDTH = ALM_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [KIND_W-1:0]            i_kind,
    input  logic [FIELD_W-1:0]           i_key,
    input  logic [FIELD_W-1:0]           i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ST_W-1:0]              o_status,
    output logic [FIELD_W-1:0]           o_item,
    output logic                         o_last,
    output logic [$clog2(NODES+1)-1:0]   o_free_head
);

    localparam int LW = $clog2(NODES + 1);

    t_store_ctl            ctl;
    logic [LW-1:0]         rd_addr;
    logic [LW-1:0]         wl_addr;
    logic [LW-1:0]         wl_data;
    logic [LW-1:0]         wv_addr;
    logic [DATA_WIDTH-1:0] wv_data;
    logic [LW-1:0]         rd_link;
    logic [DATA_WIDTH-1:0] rd_value;
    logic                  res_free;
    logic                  res_valid;
    logic [ST_W-1:0]       res_status;
    logic [FIELD_W-1:0]    res_item;
    logic                  res_last;
    logic [LW-1:0]         res_free_head;

    logic                  r_ov;
    logic [ST_W-1:0]       r_status;
    logic [FIELD_W-1:0]    r_item;
    logic                  r_last;
    logic [LW-1:0]         r_fh;

    alm_seq #(
        .NODES      (NODES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_ctl       (ctl),
        .o_rd_addr   (rd_addr),
        .o_wl_addr   (wl_addr),
        .o_wl_data   (wl_data),
        .o_wv_addr   (wv_addr),
        .o_wv_data   (wv_data),
        .i_rd_link   (rd_link),
        .i_rd_value  (rd_value),
        .i_res_free  (res_free),
        .o_res_valid (res_valid),
        .o_status    (res_status),
        .o_item      (res_item),
        .o_last      (res_last),
        .o_free_head (res_free_head)
    );

    alm_store #(
        .NODES      (NODES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_rd_addr  (rd_addr),
        .i_wl_addr  (wl_addr),
        .i_wl_data  (wl_data),
        .i_wv_addr  (wv_addr),
        .i_wv_data  (wv_data),
        .o_rd_link  (rd_link),
        .o_rd_value (rd_value)
    );

    // output register: free when empty or being taken this cycle
    assign res_free = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_valid) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_status <= res_status;
            r_item   <= res_item;
            r_last   <= res_last;
            r_fh     <= res_free_head;
        end
    end

    assign o_valid     = r_ov;
    assign o_status    = r_status;
    assign o_item      = r_item;
    assign o_last      = r_last;
    assign o_free_head = r_fh;

endmodule

### tb/alm_list_checker.sv
// ----------------------------------------------------------------------------
// alm_list_checker
// Watches both channels of the list manager, keeps its own copy of the node
// pool, works out the result words of every accepted operation and compares
// them, in order, with the words that leave the block.
// ----------------------------------------------------------------------------
module alm_list_checker
    import alm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [FIELD_W-1:0]  i_key,
    input  logic [FIELD_W-1:0]  i_value,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [ST_W-1:0]     i_status,
    input  logic [FIELD_W-1:0]  i_item,
    input  logic                i_last,
    input  logic [3:0]          i_free_head,
    output int                  o_errors,
    output int                  o_pending
);

    localparam int N = ALM_NODES;
    localparam logic [3:0] NIL = 4'(N);

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [FIELD_W-1:0] item;
        logic               last;
        logic [3:0]         free_head;
    } t_word;

    t_word              words_due[$];
    logic [3:0]         link_mem[N];
    logic [FIELD_W-1:0] data_mem[N];
    logic [3:0]         head_idx;
    logic [3:0]         free_idx;

    assign o_pending = words_due.size();

    function automatic logic [3:0] succ(logic [3:0] n);
        if (n >= NIL) return NIL;
        return (link_mem[n] >= NIL) ? NIL : link_mem[n];
    endfunction

    function automatic void push_word(logic [ST_W-1:0] st, logic [FIELD_W-1:0] it,
                                      logic lst);
        t_word w;
        w.status    = st;
        w.item      = it;
        w.last      = lst;
        w.free_head = free_idx;
        words_due.push_back(w);
    endfunction

    function automatic void release_node(logic [3:0] n);
        link_mem[n] = free_idx;
        free_idx    = n;
    endfunction

    // first node holding k and its predecessor
    function automatic logic [3:0] search(logic [FIELD_W-1:0] k, output logic [3:0] prv);
        logic [3:0] p;
        logic [3:0] n;
        p = NIL;
        n = head_idx;
        prv = NIL;
        for (int s = 0; s < N && n < NIL; s++) begin
            if (data_mem[n] == k) begin
                prv = p;
                return n;
            end
            p = n;
            n = succ(n);
        end
        return NIL;
    endfunction

    function automatic logic [3:0] tail_of(output logic [3:0] prv);
        logic [3:0] n;
        n = head_idx;
        prv = NIL;
        for (int s = 1; s < N && succ(n) < NIL; s++) begin
            prv = n;
            n = succ(n);
        end
        return n;
    endfunction

    // apply one operation to the pool and queue its result words
    function automatic void apply_op(logic [3:0] kd, logic [FIELD_W-1:0] k,
                                     logic [FIELD_W-1:0] v);
        logic [ST_W-1:0]    st;
        logic [FIELD_W-1:0] it;
        logic [3:0] m, pre, n, t, pp;
        st = ST_OK;
        it = '0;
        m = NIL;
        pre = NIL;
        if (kd == K_READ) begin
            if (head_idx >= NIL) begin
                push_word(ST_EMPTY, '0, 1'b1);
                return;
            end
            n = head_idx;
            for (int s = 0; s < N && n < NIL; s++) begin
                t = succ(n);
                push_word(ST_OK, data_mem[n], (t >= NIL) || (s + 1 == N));
                n = t;
            end
            return;
        end
        if (kd <= K_INS_AFTER) begin
            if (kd >= K_INS_BEFORE) begin
                if (head_idx >= NIL) st = ST_EMPTY;
                else begin
                    m = search(k, pre);
                    if (m >= NIL) st = ST_MISSING;
                end
            end
            if (st == ST_OK && free_idx >= NIL) st = ST_FULL;
            if (st == ST_OK) begin
                n = free_idx;
                free_idx = succ(n);
                data_mem[n] = v;
                if (kd == K_INS_HEAD || head_idx >= NIL
                    || (kd == K_INS_BEFORE && pre >= NIL)) begin
                    link_mem[n] = head_idx;
                    head_idx = n;
                end else if (kd == K_INS_TAIL) begin
                    t = tail_of(pre);
                    link_mem[n] = NIL;
                    link_mem[t] = n;
                end else if (kd == K_INS_BEFORE) begin
                    link_mem[n] = m;
                    link_mem[pre] = n;
                end else begin
                    link_mem[n] = succ(m);
                    link_mem[m] = n;
                end
            end
        end else if (kd <= K_RM_AFTER) begin
            if (head_idx >= NIL) st = ST_EMPTY;
            else if (kd == K_RM_HEAD) begin
                n = head_idx;
                it = data_mem[n];
                head_idx = succ(n);
                release_node(n);
            end else if (kd == K_RM_TAIL) begin
                t = tail_of(pre);
                it = data_mem[t];
                if (pre >= NIL) head_idx = NIL;
                else link_mem[pre] = NIL;
                release_node(t);
            end else begin
                m = search(k, pre);
                if (m >= NIL) st = ST_MISSING;
                else if (kd == K_RM_BEFORE) begin
                    if (pre >= NIL) st = ST_MISSING;
                    else begin
                        // predecessor of pre by position, not by value
                        pp = NIL;
                        n = head_idx;
                        for (int s = 0; s < N && n < NIL && n != pre; s++) begin
                            pp = n;
                            n = succ(n);
                        end
                        it = data_mem[pre];
                        if (pp >= NIL) head_idx = m;
                        else link_mem[pp] = m;
                        release_node(pre);
                    end
                end else begin
                    n = succ(m);
                    if (n >= NIL) st = ST_MISSING;
                    else begin
                        it = data_mem[n];
                        link_mem[m] = succ(n);
                        release_node(n);
                    end
                end
            end
        end
        push_word(st, it, 1'b1);
    endfunction

    // watch both channels at each edge
    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                link_mem[i] = 4'(i + 1);
                data_mem[i] = '0;
            end
            head_idx = NIL;
            free_idx = '0;
            words_due.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (words_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected word: st=%0d item=%h last=%0d free=%0d",
                                 i_status, i_item, i_last, i_free_head);
                end else begin
                    w = words_due.pop_front();
                    if (w.status !== i_status || w.item !== i_item
                        || w.last !== i_last || w.free_head !== i_free_head) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"word mismatch: exp st=%0d item=%h last=%0d free=%0d",
                                      " got st=%0d item=%h last=%0d free=%0d"},
                                     w.status, w.item, w.last, w.free_head,
                                     i_status, i_item, i_last, i_free_head);
                    end
                end
            end
            if (i_in_valid && i_in_ready) apply_op(i_kind, i_key, i_value);
        end
    end

endmodule

### tb/tb_array_linked_list_manager.sv
// ----------------------------------------------------------------------------
// tb_array_linked_list_manager
// Drives directed and random list operations with random gaps and stalls,
// a long output hold-off and a drain pause; the checker judges the words.
// ----------------------------------------------------------------------------
module tb_array_linked_list_manager;
    import alm_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [KIND_W-1:0]  i_kind;
    logic [FIELD_W-1:0] i_key;
    logic [FIELD_W-1:0] i_value;
    logic               o_valid;
    logic               i_ready;
    logic [ST_W-1:0]    o_status;
    logic [FIELD_W-1:0] o_item;
    logic               o_last;
    logic [3:0]         o_free_head;

    int errors;
    int pending;
    int idle_cycles;
    bit stim_done;
    bit hold_out;

    // values used in the list, few so that keys hit often
    logic [FIELD_W-1:0] val_pool[6];

    array_linked_list_manager uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_key(i_key), .i_value(i_value), .o_valid(o_valid),
        .i_ready(i_ready), .o_status(o_status), .o_item(o_item), .o_last(o_last),
        .o_free_head(o_free_head)
    );

    alm_list_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_kind(i_kind), .i_key(i_key), .i_value(i_value), .i_out_valid(o_valid),
        .i_out_ready(i_ready), .i_status(o_status), .i_item(o_item), .i_last(o_last),
        .i_free_head(o_free_head), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // offer one word, then wait for it to be taken
    task automatic send_op(logic [KIND_W-1:0] kd, logic [FIELD_W-1:0] k,
                           logic [FIELD_W-1:0] v, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 18) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap + 1) @(posedge i_clk);
        i_valid <= 1'b1;
        i_kind  <= kd;
        i_key   <= k;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
        i_valid <= 1'b0;
    endtask

    function automatic logic [FIELD_W-1:0] pick_val();
        return ($urandom_range(0, 7) == 0) ? $urandom() : val_pool[$urandom_range(0, 5)];
    endfunction

    // output side: random stall per word, plus one long hold-off
    initial begin
        int stall;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_out) i_ready <= 1'b0;
            else if (i_ready && o_valid) begin
                stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
                if (stall > 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    i_ready <= 1'b1;
                end
            end else i_ready <= 1'b1;
        end
    end

    // watchdog on accepted words
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int r;
        logic [KIND_W-1:0] kd;
        idle_cycles = 0;
        hold_out = 1'b0;
        stim_done = 1'b0;
        i_valid = 1'b0;
        i_kind = '0;
        i_key = '0;
        i_value = '0;
        i_rst_n = 1'b0;
        val_pool = '{32'h0, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1, 32'h8000_0000};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list cases
        send_op(K_READ, '0, '0, 0);
        send_op(K_RM_HEAD, '0, '0, 0);
        send_op(K_RM_TAIL, '0, '0, 0);
        send_op(K_INS_BEFORE, '0, 32'h1, 0);
        send_op(K_RM_AFTER, '0, '0, 0);
        // build up and fill the pool
        send_op(K_INS_TAIL, '0, 32'hFFFF_FFFF, 0);
        send_op(K_RM_TAIL, '0, '0, 0);                 // single node removal
        send_op(K_INS_HEAD, '0, 32'h0, 0);
        send_op(K_INS_TAIL, '0, 32'hFFFF_FFFF, 0);
        send_op(K_INS_BEFORE, 32'h0, 32'h5555_5555, 0); // match at head
        send_op(K_INS_AFTER, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 0);
        send_op(K_INS_AFTER, 32'h1234, 32'h1, 0);      // key missing
        send_op(K_INS_BEFORE, 32'hAAAA_AAAA, 32'h0, 0); // duplicate value
        send_op(K_INS_HEAD, '0, 32'h8000_0000, 0);
        send_op(K_INS_TAIL, '0, 32'h1, 0);
        send_op(K_INS_TAIL, '0, 32'h7, 0);
        send_op(K_INS_HEAD, '0, 32'h9, 0);             // pool full
        send_op(K_INS_AFTER, 32'h4321, 32'h9, 0);      // missing before full
        send_op(K_READ, '0, '0, 0);
        send_op(K_RM_BEFORE, 32'h8000_0000, '0, 0);    // match at head
        send_op(K_RM_AFTER, 32'h7, '0, 0);             // match at tail
        send_op(K_RM_BEFORE, 32'h0, '0, 0);
        send_op(K_RM_AFTER, 32'h0, '0, 0);
        send_op(4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_op(4'd15, '0, '0, 0);

        // long output hold-off while operations keep coming
        fork
            begin
                hold_out = 1'b1;
                repeat (120) @(posedge i_clk);
                hold_out = 1'b0;
            end
            for (int i = 0; i < 12; i++) send_op(4'($urandom_range(0, 8)), pick_val(),
                                                 pick_val(), 0);
        join

        // random part
        for (int i = 0; i < 230; i++) begin
            if (i == 110) wait (pending == 0);
            r = $urandom_range(0, 99);
            if (r < 3) kd = 4'($urandom_range(9, 15));
            else if (r < 12) kd = K_READ;
            else kd = 4'($urandom_range(0, 7));
            send_op(kd, pick_val(), pick_val(), 1);
        end
        stim_done = 1'b1;

        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
